@@ hdl/ece_pkg.sv @@
`timescale 1ns / 1ps
package ece_pkg;
   localparam int CMD_BITS = 4;
   localparam logic [3:0] CURVE_LINEAR = 4'd0;
   localparam logic [3:0] CURVE_LAST   = 4'd12;
   localparam int POW_STAGES = 4;

   typedef struct packed {
      logic       valid;
      logic [2:0] degree;
      logic [1:0] form;
      logic       linear;
   } ctl_type;

   localparam logic [1:0] FORM_IN    = 2'd0;
   localparam logic [1:0] FORM_OUT   = 2'd1;
   localparam logic [1:0] FORM_INOUT = 2'd2;
endpackage

@@ hdl/ece_div_cell.sv @@
`timescale 1ns / 1ps
module ece_div_cell #(
   parameter int TIME_BITS = 48,
   parameter int QB = 17
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ece_pkg::ctl_type     ctl_i,
   input  logic                 sat_i,
   input  logic [TIME_BITS-1:0] rem_i,
   input  logic [TIME_BITS-1:0] den_i,
   input  logic [QB-1:0]        q_i,
   output ece_pkg::ctl_type     ctl_o,
   output logic                 sat_o,
   output logic [TIME_BITS-1:0] rem_o,
   output logic [TIME_BITS-1:0] den_o,
   output logic [QB-1:0]        q_o
);
   import ece_pkg::*;
   logic [TIME_BITS-1:0] gap, rem_in;
   logic                 bit_in;
   always_comb begin
      gap = den_i - rem_i;
      bit_in = rem_i >= gap;
      rem_in = bit_in ? rem_i - gap : rem_i + rem_i;
   end
   always_ff @(posedge clock) begin
      if (reset) ctl_o.valid <= 1'b0;
      else ctl_o.valid <= ctl_i.valid;
      ctl_o.degree <= ctl_i.degree;
      ctl_o.form   <= ctl_i.form;
      ctl_o.linear <= ctl_i.linear;
      sat_o <= sat_i;
      rem_o <= rem_in;
      den_o <= den_i;
      q_o   <= {q_i[QB-2:0], bit_in};
   end
endmodule

@@ hdl/ece_pow_cell.sv @@
`timescale 1ns / 1ps
module ece_pow_cell #(
   parameter int FRAC_BITS = 16,
   parameter logic [2:0] STEP = 3'd2
) (
   input  logic               clock,
   input  logic               reset,
   input  ece_pkg::ctl_type   ctl_i,
   input  logic [FRAC_BITS:0] t_i,
   input  logic [FRAC_BITS:0] x_i,
   input  logic [FRAC_BITS:0] p_i,
   output ece_pkg::ctl_type   ctl_o,
   output logic [FRAC_BITS:0] t_o,
   output logic [FRAC_BITS:0] x_o,
   output logic [FRAC_BITS:0] p_o
);
   import ece_pkg::*;
   localparam int PW = 2 * (FRAC_BITS + 1);
   logic [PW-1:0] prod;
   always_comb begin
      prod = PW'(p_i) * PW'(x_i) + (PW'(1) << (FRAC_BITS - 1));
   end
   always_ff @(posedge clock) begin
      if (reset) ctl_o.valid <= 1'b0;
      else ctl_o.valid <= ctl_i.valid;
      ctl_o.degree <= ctl_i.degree;
      ctl_o.form   <= ctl_i.form;
      ctl_o.linear <= ctl_i.linear;
      t_o <= t_i;
      x_o <= x_i;
      p_o <= (ctl_i.degree >= STEP) ? prod[FRAC_BITS +: FRAC_BITS+1] : p_i;
   end
endmodule

@@ hdl/easing_curve_evaluator_core.sv @@
`timescale 1ns / 1ps
// Takes one item per clock and answers each with one rsp_strobe pulse: a chain
// of FRAC_BITS + 1 restoring-division cells forms the ratio, a register rounds
// and clamps it, four multiplier cells build the power and one register forms
// the curve. busy is always low and the receiver cannot stall the pipeline.
module easing_curve_evaluator_core #(
   parameter int FRAC_BITS = 16,
   parameter int TIME_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [3:0]           req_cmd,
   input  logic [TIME_BITS-1:0] req_elapsed_ns,
   input  logic [TIME_BITS-1:0] req_duration_ns,
   output logic                 rsp_strobe,
   output logic [FRAC_BITS:0]   rsp_eased_progress
);
   import ece_pkg::*;
   localparam int QB = FRAC_BITS + 1;
   localparam int ND = FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
   localparam logic [FRAC_BITS:0] HALF = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);

   ctl_type              dctl [ND+1];
   logic                 dsat [ND+1];
   logic [TIME_BITS-1:0] drem [ND+1];
   logic [TIME_BITS-1:0] dden [ND+1];
   logic [QB-1:0]        dq   [ND+1];

   ctl_type     ctl_in;
   logic [3:0]  m1;
   always_comb begin
      m1 = req_cmd - 4'd1;
      ctl_in.valid = start;
      ctl_in.linear = (req_cmd == CURVE_LINEAR) || (req_cmd > CURVE_LAST);
      if (m1 < 4'd3) begin
         ctl_in.degree = 3'd2;
         ctl_in.form = 2'(m1);
      end else if (m1 < 4'd6) begin
         ctl_in.degree = 3'd3;
         ctl_in.form = 2'(m1 - 4'd3);
      end else if (m1 < 4'd9) begin
         ctl_in.degree = 3'd4;
         ctl_in.form = 2'(m1 - 4'd6);
      end else begin
         ctl_in.degree = 3'd5;
         ctl_in.form = 2'(m1 - 4'd9);
      end
      if (ctl_in.linear) begin
         ctl_in.degree = 3'd1;
         ctl_in.form = FORM_IN;
      end
   end
   assign busy = 1'b0;
   assign dctl[0] = ctl_in;
   assign dsat[0] = (req_duration_ns == '0) || (req_elapsed_ns >= req_duration_ns);
   assign drem[0] = req_elapsed_ns;
   assign dden[0] = req_duration_ns;
   assign dq[0]   = '0;

   for (genvar i = 0; i < ND; i++) begin : g_div
      ece_div_cell #(.TIME_BITS(TIME_BITS), .QB(QB)) u_cell (
         .clock(clock), .reset(reset),
         .ctl_i(dctl[i]), .sat_i(dsat[i]), .rem_i(drem[i]), .den_i(dden[i]), .q_i(dq[i]),
         .ctl_o(dctl[i+1]), .sat_o(dsat[i+1]), .rem_o(drem[i+1]), .den_o(dden[i+1]),
         .q_o(dq[i+1])
      );
   end

   ctl_type            tctl_ff;
   logic [FRAC_BITS:0] t_ff, x_ff;
   logic [FRAC_BITS:0] t_in, x_in;
   logic [QB:0]        qr;
   always_comb begin
      qr = ({1'b0, dq[ND]} + (QB+1)'(1)) >> 1;
      t_in = dsat[ND] ? ONE : qr[FRAC_BITS:0];
      x_in = (dctl[ND].form == FORM_IN) ||
             ((dctl[ND].form == FORM_INOUT) && (t_in < HALF)) ? t_in : ONE - t_in;
   end
   always_ff @(posedge clock) begin
      if (reset) tctl_ff.valid <= 1'b0;
      else tctl_ff.valid <= dctl[ND].valid;
      tctl_ff.degree <= dctl[ND].degree;
      tctl_ff.form   <= dctl[ND].form;
      tctl_ff.linear <= dctl[ND].linear;
      t_ff <= t_in;
      x_ff <= x_in;
   end

   ctl_type            pctl [POW_STAGES+1];
   logic [FRAC_BITS:0] pt   [POW_STAGES+1];
   logic [FRAC_BITS:0] px   [POW_STAGES+1];
   logic [FRAC_BITS:0] pp   [POW_STAGES+1];
   assign pctl[0] = tctl_ff;
   assign pt[0] = t_ff;
   assign px[0] = x_ff;
   assign pp[0] = x_ff;
   for (genvar k = 0; k < POW_STAGES; k++) begin : g_pow
      ece_pow_cell #(.FRAC_BITS(FRAC_BITS), .STEP(3'(k + 2))) u_cell (
         .clock(clock), .reset(reset),
         .ctl_i(pctl[k]), .t_i(pt[k]), .x_i(px[k]), .p_i(pp[k]),
         .ctl_o(pctl[k+1]), .t_o(pt[k+1]), .x_o(px[k+1]), .p_o(pp[k+1])
      );
   end

   logic [FRAC_BITS+4:0] sh, y;
   logic                 lower;
   ctl_type              ec;
   always_comb begin
      ec = pctl[POW_STAGES];
      sh = (FRAC_BITS+5)'(pp[POW_STAGES]) << (ec.degree - 3'd1);
      lower = pt[POW_STAGES] < HALF;
      case (ec.form)
         FORM_IN:    y = (FRAC_BITS+5)'(pp[POW_STAGES]);
         FORM_OUT:   y = (FRAC_BITS+5)'(ONE) - (FRAC_BITS+5)'(pp[POW_STAGES]);
         FORM_INOUT: y = lower ? sh : (FRAC_BITS+5)'(ONE) - sh;
         default:    y = (FRAC_BITS+5)'(pt[POW_STAGES]);
      endcase
      if (ec.linear) y = (FRAC_BITS+5)'(pt[POW_STAGES]);
      if (y > (FRAC_BITS+5)'(ONE)) y = (FRAC_BITS+5)'(ONE);
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else rsp_strobe <= ec.valid;
      rsp_eased_progress <= y[FRAC_BITS:0];
   end

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_eased_progress <= ONE) else $error("progress above one");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      tctl_ff.valid && tctl_ff.linear |-> t_ff <= ONE) else $error("ratio above one");
   a_lat: assert property (@(posedge clock) disable iff (reset)
      tctl_ff.valid |-> ##(POW_STAGES+1) rsp_strobe) else $error("lost result");
endmodule
